FILE: sv/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register indexes and payload types for the depth pixel
// backprojection unit.
// ----------------------------------------------------------------------------
`default_nettype none
package dpb_pkg;
    localparam int MaxColumns = 4096;
    localparam int MaxRows    = 4096;
    localparam int ColW       = 12;
    localparam int RowW       = 12;

    localparam logic [2:0] REG_DEPTH_SCALE = 3'd0;
    localparam logic [2:0] REG_FOCAL_X     = 3'd1;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd2;
    localparam logic [2:0] REG_CENTER_X    = 3'd3;
    localparam logic [2:0] REG_CENTER_Y    = 3'd4;

    // quotient widths of the two dividers
    localparam int ZQ_W  = 32;   // depth<<16 / scale, 32 bits kept
    localparam int NUM_W = 56;   // |diff| (24) * z (32)
    localparam int XQ_W  = 56;

    // shared divider geometry: divisor and tag widths
    localparam int DIV_DW = 24;
    localparam int DIV_TW = 61;  // valid, z, rgb, neg/zero flags

    localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

    typedef struct packed {
        logic [15:0] depth_value;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pixel_t;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic [31:0]        point_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
        logic               saturated;
    } point_t;

    typedef struct packed {
        logic [15:0] depth_scale;
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [23:0] center_x;
        logic [23:0] center_y;
    } cam_cfg_t;
endpackage
`default_nettype wire

FILE: sv/dpb_stream_if.sv
// ----------------------------------------------------------------------------
// dpb_stream_if
// Valid/ready channels, each carrying one pixel_t or one point_t word.
// ----------------------------------------------------------------------------
`default_nettype none
interface dpb_pixel_if import dpb_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dpb_point_if import dpb_pkg::*; ();
    logic   valid;
    logic   ready;
    point_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Pinhole back-projection of RGB-D pixels into colored 3D points.
// ----------------------------------------------------------------------------
// One pixel word may enter every clock while the pipe advances. Words pass
// through the z divider, the offset/multiply register, the x/y dividers and
// the saturate register; both dividers are bit-per-stage pipelines. The
// whole pipe advances together whenever the output register is empty or
// being drained, so a stall at the output freezes every stage and nothing
// is lost or repeated. Pixels with zero depth or outside the image travel
// with valid low and produce no word. A zero depth_scale gives z = all
// ones; a zero focal length saturates x/y unless the numerator is zero.
// ----------------------------------------------------------------------------
`default_nettype none
module depth_pixel_backprojection_unit import dpb_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    dpb_pixel_if.sink        pixel_in,
    dpb_point_if.source      point_out
);
    localparam int CT_W = 1 + 12 + 12 + 24;   // valid, col, row, rgb
    localparam int XT_W = 1 + 32 + 24 + 2 + 2; // valid, z, rgb, neg/zero flags

    cam_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= 16'd1000;
            cfg_reg.focal_x     <= 24'd134400;
            cfg_reg.focal_y     <= 24'd134400;
            cfg_reg.center_x    <= 24'd81792;
            cfg_reg.center_y    <= 24'd61312;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEPTH_SCALE: cfg_reg.depth_scale <= cfg_data[15:0];
                REG_FOCAL_X:     cfg_reg.focal_x     <= cfg_data;
                REG_FOCAL_Y:     cfg_reg.focal_y     <= cfg_data;
                REG_CENTER_X:    cfg_reg.center_x    <= cfg_data;
                REG_CENTER_Y:    cfg_reg.center_y    <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advance: output register free or draining
    logic   out_vld_reg;
    point_t out_reg;
    logic   adv;
    assign adv            = !out_vld_reg || point_out.ready;
    assign pixel_in.ready = adv;

    // ---- stage A: z = (depth << 16) / scale ----
    logic        in_ok;
    logic [DIV_TW-1:0] a_tag, a_tag_out;
    logic [NUM_W-1:0]  z_quo;
    assign in_ok = pixel_in.valid && (pixel_in.data.depth_value != '0)
                   && (32'(pixel_in.data.column) < 32'(MaxColumns))
                   && (32'(pixel_in.data.row) < 32'(MaxRows));
    assign a_tag = {12'h000, in_ok, pixel_in.data.column, pixel_in.data.row,
                    pixel_in.data.blue, pixel_in.data.green, pixel_in.data.red};

    dpb_div_pipe u_zdiv (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .num({24'h000000, pixel_in.data.depth_value, 16'h0000}),
        .den({8'h00, cfg_reg.depth_scale}),
        .tag_in(a_tag), .quo(z_quo), .tag_out(a_tag_out)
    );

    // ---- stage B: offsets and products ----
    logic        b_vld_reg;
    logic [31:0] b_z_reg;
    logic [23:0] b_rgb_reg;
    logic [NUM_W-1:0] b_nx_reg, b_ny_reg;
    logic        b_negx_reg, b_negy_reg;

    logic [11:0] a_col, a_row;
    logic [23:0] px, py, dx, dy;
    logic        ngx, ngy;
    logic [31:0] zv;
    assign a_col = a_tag_out[47:36];
    assign a_row = a_tag_out[35:24];
    assign px = {4'h0, a_col, 8'h00};
    assign py = {4'h0, a_row, 8'h00};
    assign ngx = cfg_reg.center_x > px;
    assign ngy = cfg_reg.center_y > py;
    assign dx = ngx ? cfg_reg.center_x - px : px - cfg_reg.center_x;
    assign dy = ngy ? cfg_reg.center_y - py : py - cfg_reg.center_y;
    // quotient only exceeds 32 bits on divide by zero, which wants all ones
    assign zv = (z_quo[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : z_quo[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_tag_out[CT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_z_reg    <= zv;
            b_rgb_reg  <= a_tag_out[23:0];
            b_nx_reg   <= NUM_W'(dx) * NUM_W'(zv);
            b_ny_reg   <= NUM_W'(dy) * NUM_W'(zv);
            b_negx_reg <= ngx;
            b_negy_reg <= ngy;
        end
    end

    // ---- stage C: x and y dividers ----
    logic [XT_W-1:0] c_tag, cx_tag_out, cy_tag_out;
    logic [XQ_W-1:0] qx, qy;
    assign c_tag = {b_vld_reg, b_z_reg, b_rgb_reg, b_negx_reg, b_negy_reg,
                    b_nx_reg == '0, b_ny_reg == '0};

    dpb_div_pipe u_xdiv (
        .clk(clk), .rst_n(rst_n), .en(adv), .num(b_nx_reg),
        .den(cfg_reg.focal_x), .tag_in(c_tag), .quo(qx), .tag_out(cx_tag_out)
    );
    dpb_div_pipe u_ydiv (
        .clk(clk), .rst_n(rst_n), .en(adv), .num(b_ny_reg),
        .den(cfg_reg.focal_y), .tag_in(c_tag), .quo(qy), .tag_out(cy_tag_out)
    );

    // ---- stage D: sign, saturate, output register ----
    logic        nxz, nyz, nx_neg, ny_neg, sx, sy;
    logic [47:0] rx, ry;
    assign nx_neg = cx_tag_out[3];
    assign ny_neg = cx_tag_out[2];
    assign nxz    = cx_tag_out[1];
    assign nyz    = cx_tag_out[0];

    always_comb
    begin
        // divide by zero yields all ones, which always saturates
        sx = 1'b0;
        rx = '0;
        if (!nxz)
        begin
            if (nx_neg)
            begin
                sx = qx > XQ_W'(NEG_LIMIT);
                rx = sx ? NEG_LIMIT : 48'(-qx);
            end
            else
            begin
                sx = qx > XQ_W'(POS_LIMIT);
                rx = sx ? POS_LIMIT : qx[47:0];
            end
        end
        sy = 1'b0;
        ry = '0;
        if (!nyz)
        begin
            if (ny_neg)
            begin
                sy = qy > XQ_W'(NEG_LIMIT);
                ry = sy ? NEG_LIMIT : 48'(-qy);
            end
            else
            begin
                sy = qy > XQ_W'(POS_LIMIT);
                ry = sy ? POS_LIMIT : qy[47:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= cx_tag_out[XT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.point_x   <= rx;
            out_reg.point_y   <= ry;
            out_reg.point_z   <= cx_tag_out[59:28];
            out_reg.out_blue  <= cx_tag_out[27:20];
            out_reg.out_green <= cx_tag_out[19:12];
            out_reg.out_red   <= cx_tag_out[11:4];
            out_reg.saturated <= (sx || sy) && (cy_tag_out == cx_tag_out);
        end
    end

    assign point_out.valid = out_vld_reg;
    assign point_out.data  = out_reg;
endmodule
`default_nettype wire

FILE: sv/dpb_div_pipe.sv
// ----------------------------------------------------------------------------
// dpb_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a global
// stage enable. Divide by zero yields all ones.
// ----------------------------------------------------------------------------
`default_nettype none
module dpb_div_pipe import dpb_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DIV_DW-1:0] den,
    input  wire logic [DIV_TW-1:0] tag_in,
    output logic      [NUM_W-1:0]  quo,
    output logic      [DIV_TW-1:0] tag_out
);
    // stage s holds the partial remainder, shifted numerator and divisor
    logic [DIV_DW:0]   rem_reg [NUM_W];
    logic [NUM_W-1:0]  n_reg   [NUM_W];
    logic [DIV_DW-1:0] d_reg   [NUM_W];
    logic [DIV_TW-1:0] t_reg   [NUM_W];

    logic [DIV_DW:0]   rem_next [NUM_W];
    logic [NUM_W-1:0]  n_next   [NUM_W];

    always_comb
    begin
        for (int s = 0; s < NUM_W; s++)
        begin
            logic [DIV_DW:0]   r_in;
            logic [NUM_W-1:0]  q_in;
            logic [DIV_DW-1:0] d_in;
            logic [DIV_DW+1:0] trial;
            r_in  = (s == 0) ? '0 : rem_reg[(s == 0) ? 0 : s-1];
            q_in  = (s == 0) ? num : n_reg[(s == 0) ? 0 : s-1];
            d_in  = (s == 0) ? den : d_reg[(s == 0) ? 0 : s-1];
            trial = {r_in, q_in[NUM_W-1]};
            if (trial >= {2'b00, d_in})
            begin
                rem_next[s] = (DIV_DW+1)'(trial - {2'b00, d_in});
                n_next[s]   = {q_in[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = trial[DIV_DW:0];
                n_next[s]   = {q_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NUM_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                n_reg[s]   <= n_next[s];
                d_reg[s]   <= (s == 0) ? den : d_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // tags carry the valid bit, so they come out of reset cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_W; s++)
                t_reg[s] <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < NUM_W; s++)
                t_reg[s] <= (s == 0) ? tag_in : t_reg[(s == 0) ? 0 : s-1];
        end
    end

    assign quo     = n_reg[NUM_W-1];
    assign tag_out = t_reg[NUM_W-1];
endmodule
`default_nettype wire

FILE: sv/dpb_checker.sv
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks on the backprojection unit.
// ----------------------------------------------------------------------------
`default_nettype none
module dpb_checker import dpb_pkg::*; (
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_ready,
    input wire logic   out_valid,
    input wire logic   out_ready,
    input wire point_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.saturated |->
        out_data.point_x != 48'h7FFF_FFFF_FFFF || out_data.point_z != '0)
        else $error("unflagged positive extreme with zero z");
endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(pixel_in.ready),
    .out_valid(point_out.valid), .out_ready(point_out.ready),
    .out_data(point_out.data)
);
`default_nettype wire
